// ===== rtl/go_back_n_sender_window_unit_macros.svh =====
// Assertion helpers used by the top-level RTL file.
`ifndef GO_BACK_N_SENDER_WINDOW_UNIT_MACROS_SVH
`define GO_BACK_N_SENDER_WINDOW_UNIT_MACROS_SVH

// Same-cycle implication.
`define GBNSW_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define GBNSW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/gbnsw_pkg.sv =====
`timescale 1ns / 1ps

package gbnsw_pkg;

    // Sequence space is a power of two, so sequence math wraps naturally.
    localparam int SEQ_SPACE      = 256;
    localparam int SEQ_W          = $clog2(SEQ_SPACE);
    localparam int MAX_WINDOW_DEF = 16;

    localparam int CMD_W      = 2;
    localparam int PAYLOAD_W  = 32;
    localparam int ACK_W      = 8;
    localparam int STATUS_W   = 3;
    localparam int TXSEQ_W    = 8;
    localparam int FLIGHT_W   = 5;
    localparam int BASE_W     = 8;
    localparam int WSIZE_W    = 5;
    localparam int TIMER_W    = 20;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    localparam logic [WSIZE_W-1:0] WSIZE_RST     = WSIZE_W'(16);
    localparam logic [TIMER_W-1:0] TIMEOUT_RST   = TIMER_W'(1000);
    localparam logic [SEQ_W-1:0]   START_SEQ_RST = SEQ_W'(0);

    typedef enum logic [CMD_W-1:0] {
        CMD_SEND = 2'd0,
        CMD_ACK  = 2'd1,
        CMD_TICK = 2'd2
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_SEND     = 3'd0,
        ST_RESEND   = 3'd1,
        ST_REFUSED  = 3'd2,
        ST_ACK_ADV  = 3'd3,
        ST_ACK_IGN  = 3'd4,
        ST_ACK_BAD  = 3'd5
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW_SIZE = 2'd0,
        REG_TIMEOUT     = 2'd1,
        REG_START_SEQ   = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic slot_free;
        logic burst;
        logic burst_last;
    } dp_stat_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic rd_issue;
        logic emit;
    } dp_ctrl_t;

endpackage

// ===== rtl/gbnsw_ram.sv =====
`timescale 1ns / 1ps

module gbnsw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                    aclk,
    input  logic                                    wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                        wr_data,
    input  logic                                    rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/gbnsw_dp.sv =====
`timescale 1ns / 1ps

module gbnsw_dp import gbnsw_pkg::*; #(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  dp_ctrl_t              ctl,
    output dp_stat_t              stat,
    input  logic [CMD_W-1:0]      s_command,
    input  logic [PAYLOAD_W-1:0]  s_payload,
    input  logic [ACK_W-1:0]      s_ack_seq,
    input  logic                  s_ack_good,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [STATUS_W-1:0]   m_status,
    output logic [TXSEQ_W-1:0]    m_tx_seq,
    output logic [PAYLOAD_W-1:0]  m_tx_payload,
    output logic                  m_last,
    output logic [FLIGHT_W-1:0]   m_in_flight,
    output logic [BASE_W-1:0]     m_window_base
);

    localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam logic [SEQ_W-1:0]   MAXW_SEQ  = SEQ_W'(MAX_WINDOW);
    localparam logic [TIMER_W-1:0] TIMER_MAX = '1;

    // ring slot arithmetic: both operands stay below 2*MAX_WINDOW
    function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] a,
                                                  input logic [CNT_W-1:0] b);
        logic [SUM_W-1:0] s;
        s = SUM_W'(a) + SUM_W'(b);
        if (s >= SUM_W'(MAX_WINDOW)) begin
            s = s - SUM_W'(MAX_WINDOW);
        end
        return s[IDX_W-1:0];
    endfunction

    // captured request
    logic [CMD_W-1:0]     cmd_reg, cmd_next;
    logic [PAYLOAD_W-1:0] pay_reg, pay_next;
    logic [SEQ_W-1:0]     ack_reg, ack_next;
    logic                 good_reg, good_next;

    // configuration
    logic [WSIZE_W-1:0]   wsize_reg, wsize_next;
    logic [TIMER_W-1:0]   tmo_reg, tmo_next;

    // window and timer
    logic [SEQ_W-1:0]     base_reg, base_next;
    logic [SEQ_W-1:0]     snd_seq_reg, snd_seq_next;
    logic [IDX_W-1:0]     head_reg, head_next;
    logic [TIMER_W-1:0]   tcnt_reg, tcnt_next;
    logic                 trun_reg, trun_next;
    logic [CNT_W-1:0]     ridx_reg, ridx_next;

    // output register
    logic                 m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0]  m_status_reg, m_status_next;
    logic [TXSEQ_W-1:0]   m_tx_seq_reg, m_tx_seq_next;
    logic [PAYLOAD_W-1:0] m_tx_payload_reg, m_tx_payload_next;
    logic                 m_last_reg, m_last_next;
    logic [FLIGHT_W-1:0]  m_in_flight_reg, m_in_flight_next;
    logic [BASE_W-1:0]    m_window_base_reg, m_window_base_next;

    logic [SEQ_W-1:0]     n_out;
    logic [CNT_W-1:0]     n_c;
    logic [SEQ_W-1:0]     ws;
    logic [SEQ_W-1:0]     eff_win;
    logic                 full;
    logic [SEQ_W-1:0]     d;
    logic                 ack_ok;
    logic [TIMER_W-1:0]   tcnt_inc;
    logic [TIMER_W-1:0]   limit;
    logic                 hit;
    logic [SEQ_W-1:0]     flight_after;

    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic [IDX_W-1:0]     rd_addr;
    logic [PAYLOAD_W-1:0] rd_data;

    assign n_out   = snd_seq_reg - base_reg;
    assign n_c     = n_out[CNT_W-1:0];
    assign ws      = SEQ_W'(wsize_reg);
    assign eff_win = (ws == '0) ? SEQ_W'(1) : ((ws > MAXW_SEQ) ? MAXW_SEQ : ws);
    assign full    = (n_out >= eff_win);

    assign d       = ack_reg + SEQ_W'(1) - base_reg;
    assign ack_ok  = good_reg && (d != '0) && (d <= n_out);

    assign tcnt_inc = (tcnt_reg == TIMER_MAX) ? tcnt_reg : tcnt_reg + TIMER_W'(1);
    assign limit    = (tmo_reg == '0) ? TIMER_W'(1) : tmo_reg;
    assign hit      = (tcnt_inc >= limit);

    assign stat.slot_free  = !m_valid_reg || m_ready;
    assign stat.burst      = (cmd_reg == CMD_TICK) && trun_reg && hit && (n_out != '0);
    assign stat.burst_last = ((ridx_reg + CNT_W'(1)) == n_c);

    assign wr_en   = ctl.exec && (cmd_reg == CMD_SEND) && !full;
    assign wr_addr = ring_add(head_reg, n_c);
    assign rd_addr = ring_add(head_reg, ridx_reg);

    gbnsw_ram #(
        .WIDTH (PAYLOAD_W),
        .DEPTH (MAX_WINDOW)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (pay_reg),
        .rd_en   (ctl.rd_issue),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb begin
        cmd_next           = cmd_reg;
        pay_next           = pay_reg;
        ack_next           = ack_reg;
        good_next          = good_reg;
        wsize_next         = wsize_reg;
        tmo_next           = tmo_reg;
        base_next          = base_reg;
        snd_seq_next       = snd_seq_reg;
        head_next          = head_reg;
        tcnt_next          = tcnt_reg;
        trun_next          = trun_reg;
        ridx_next          = ridx_reg;
        m_status_next      = m_status_reg;
        m_tx_seq_next      = m_tx_seq_reg;
        m_tx_payload_next  = m_tx_payload_reg;
        m_last_next        = m_last_reg;
        m_in_flight_next   = m_in_flight_reg;
        m_window_base_next = m_window_base_reg;
        m_valid_next       = m_ready ? 1'b0 : m_valid_reg;

        if (ctl.capture) begin
            cmd_next  = s_command;
            pay_next  = s_payload;
            ack_next  = SEQ_W'(s_ack_seq);
            good_next = s_ack_good;
        end

        if (cfg_valid) begin
            case (cfg_reg_t'(cfg_index))
                REG_WINDOW_SIZE: wsize_next = cfg_data[WSIZE_W-1:0];
                REG_TIMEOUT:     tmo_next   = cfg_data[TIMER_W-1:0];
                REG_START_SEQ: begin
                    base_next    = cfg_data[SEQ_W-1:0];
                    snd_seq_next = cfg_data[SEQ_W-1:0];
                    head_next    = '0;
                    tcnt_next    = '0;
                    trun_next    = 1'b0;
                end
                default: ;
            endcase
        end

        if (ctl.exec) begin
            case (cmd_t'(cmd_reg))
                CMD_SEND: begin
                    m_valid_next      = 1'b1;
                    m_tx_seq_next     = TXSEQ_W'(snd_seq_reg);
                    if (full) begin
                        m_status_next     = ST_REFUSED;
                        m_tx_payload_next = '0;
                    end else begin
                        m_status_next     = ST_SEND;
                        m_tx_payload_next = pay_reg;
                        snd_seq_next      = snd_seq_reg + SEQ_W'(1);
                        if (n_out == '0) begin
                            tcnt_next = '0;
                            trun_next = 1'b1;
                        end
                    end
                end
                CMD_ACK: begin
                    m_valid_next      = 1'b1;
                    m_tx_seq_next     = '0;
                    m_tx_payload_next = '0;
                    if (!good_reg) begin
                        m_status_next = ST_ACK_BAD;
                    end else if (!ack_ok) begin
                        m_status_next = ST_ACK_IGN;
                    end else begin
                        m_status_next = ST_ACK_ADV;
                        base_next     = base_reg + d;
                        head_next     = ring_add(head_reg, d[CNT_W-1:0]);
                        tcnt_next     = '0;
                        trun_next     = ((base_reg + d) != snd_seq_reg);
                    end
                end
                CMD_TICK: begin
                    if (trun_reg) begin
                        if (hit) begin
                            tcnt_next = '0;
                            ridx_next = '0;
                        end else begin
                            tcnt_next = tcnt_inc;
                        end
                    end
                end
                default: ;
            endcase
        end

        if (ctl.emit) begin
            m_valid_next      = 1'b1;
            m_status_next     = ST_RESEND;
            m_tx_seq_next     = TXSEQ_W'(base_reg + SEQ_W'(ridx_reg));
            m_tx_payload_next = rd_data;
            ridx_next         = ridx_reg + CNT_W'(1);
        end

        flight_after = snd_seq_next - base_next;

        // occupancy and base reported after the step
        if (ctl.exec || ctl.emit) begin
            m_last_next        = ctl.exec ? 1'b1 : stat.burst_last;
            m_in_flight_next   = flight_after[FLIGHT_W-1:0];
            m_window_base_next = BASE_W'(base_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wsize_reg   <= WSIZE_RST;
            tmo_reg     <= TIMEOUT_RST;
            base_reg    <= START_SEQ_RST;
            snd_seq_reg <= START_SEQ_RST;
            head_reg    <= '0;
            tcnt_reg    <= '0;
            trun_reg    <= 1'b0;
            ridx_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            wsize_reg   <= wsize_next;
            tmo_reg     <= tmo_next;
            base_reg    <= base_next;
            snd_seq_reg <= snd_seq_next;
            head_reg    <= head_next;
            tcnt_reg    <= tcnt_next;
            trun_reg    <= trun_next;
            ridx_reg    <= ridx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg           <= cmd_next;
        pay_reg           <= pay_next;
        ack_reg           <= ack_next;
        good_reg          <= good_next;
        m_status_reg      <= m_status_next;
        m_tx_seq_reg      <= m_tx_seq_next;
        m_tx_payload_reg  <= m_tx_payload_next;
        m_last_reg        <= m_last_next;
        m_in_flight_reg   <= m_in_flight_next;
        m_window_base_reg <= m_window_base_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_tx_seq      = m_tx_seq_reg;
    assign m_tx_payload  = m_tx_payload_reg;
    assign m_last        = m_last_reg;
    assign m_in_flight   = m_in_flight_reg;
    assign m_window_base = m_window_base_reg;

endmodule

// ===== rtl/gbnsw_ctrl.sv =====
`timescale 1ns / 1ps

module gbnsw_ctrl import gbnsw_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  dp_stat_t stat,
    output dp_ctrl_t ctl
);

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (stat.slot_free) begin
                    state_next = stat.burst ? S_READ : S_IDLE;
                end
            end
            S_READ: state_next = S_EMIT;
            S_EMIT: begin
                if (stat.slot_free) begin
                    state_next = stat.burst_last ? S_IDLE : S_READ;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        s_ready      = 1'b0;
        ctl          = '0;
        case (state_reg)
            S_IDLE: begin
                s_ready     = 1'b1;
                ctl.capture = s_valid;
            end
            S_EXEC: ctl.exec     = stat.slot_free;
            S_READ: ctl.rd_issue = 1'b1;
            S_EMIT: ctl.emit     = stat.slot_free;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/go_back_n_sender_window_unit.sv =====
// Go-Back-N sender window: send, cumulative ack and timer tick requests.
// Send/ack request: accepted, executed once the result slot is free, result registered; no new request until done.
// Timeout burst: the tick executes, then each resent packet takes a ring RAM read step, then an emit step.
// A stalled result port holds the unit in its execute or emit step.
// Reset (aresetn, synchronous, low): window empty at sequence 0, timer stopped,
// registers at defaults; ring contents are not cleared.
`timescale 1ns / 1ps
`include "go_back_n_sender_window_unit_macros.svh"

module go_back_n_sender_window_unit import gbnsw_pkg::*; #(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [CMD_W-1:0]      s_command,
    input  logic [PAYLOAD_W-1:0]  s_payload,
    input  logic [ACK_W-1:0]      s_ack_seq,
    input  logic                  s_ack_good,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [STATUS_W-1:0]   m_status,
    output logic [TXSEQ_W-1:0]    m_tx_seq,
    output logic [PAYLOAD_W-1:0]  m_tx_payload,
    output logic                  m_last,
    output logic [FLIGHT_W-1:0]   m_in_flight,
    output logic [BASE_W-1:0]     m_window_base,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    dp_stat_t stat;
    dp_ctrl_t ctl;

    // register writes never stall
    assign cfg_ready = 1'b1;

    gbnsw_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .ctl     (ctl)
    );

    gbnsw_dp #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .ctl           (ctl),
        .stat          (stat),
        .s_command     (s_command),
        .s_payload     (s_payload),
        .s_ack_seq     (s_ack_seq),
        .s_ack_good    (s_ack_good),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_tx_seq      (m_tx_seq),
        .m_tx_payload  (m_tx_payload),
        .m_last        (m_last),
        .m_in_flight   (m_in_flight),
        .m_window_base (m_window_base)
    );

    `GBNSW_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready, "request accepted while previous one executes")
    `GBNSW_ASSERT_IMPL(a_single_result_last, aclk, aresetn, m_valid && (m_status != ST_RESEND), m_last, "single result not marked last")
    `GBNSW_ASSERT_IMPL(a_emit_has_slot, aclk, aresetn, ctl.exec || ctl.emit, !m_valid || m_ready, "result loaded over an untaken result")

endmodule
